>>> rtl/core/sha0_pkg.sv
// Shared types, constants and round functions for the SHA-0 digest core.
package sha0_pkg;

	typedef logic [31:0] word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LEN,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} state_t;

	localparam int NUM_WORDS = 5;
	localparam int BUF_WORDS = 16;

	localparam logic [6:0] LAST_ROUND = 7'd79;
	localparam logic [5:0] LEN_FILL = 6'd56;
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [2:0] LAST_WORD = 3'd4;
	localparam logic [63:0] BITS_PER_BYTE = 64'd8;

	localparam word_t K0 = 32'h5A827999;
	localparam word_t K1 = 32'h6ED9EBA1;
	localparam word_t K2 = 32'h8F1BBCDC;
	localparam word_t K3 = 32'hCA62C1D6;

	localparam word_t INIT_HASH [NUM_WORDS] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	// Byte path and schedule control for the block buffer
	typedef struct packed {
		logic        byte_en;
		logic [7:0]  byte_val;
		logic [5:0]  fill;
		logic        len_en;
		logic [63:0] bit_len;
		logic        shift;
	} buf_ctl_t;

	// Round unit control
	typedef struct packed {
		logic       start;
		logic       step;
		logic       finish;
		logic       reinit;
		logic [6:0] round;
	} rnd_ctl_t;

	function automatic word_t round_f(logic [6:0] r, word_t b, word_t c, word_t d);
		word_t f;
		if (r < 7'd20) begin
			f = (b & c) | (~b & d);
		end else if (r < 7'd40) begin
			f = b ^ c ^ d;
		end else if (r < 7'd60) begin
			f = (b & c) | (b & d) | (c & d);
		end else begin
			f = b ^ c ^ d;
		end
		return f;
	endfunction

	function automatic word_t round_k(logic [6:0] r);
		word_t k;
		if (r < 7'd20) begin
			k = K0;
		end else if (r < 7'd40) begin
			k = K1;
		end else if (r < 7'd60) begin
			k = K2;
		end else begin
			k = K3;
		end
		return k;
	endfunction

endpackage

>>> rtl/core/sha0_message_digest.sv
// A byte that completes a block starts a compression: 80 rounds on the shared round unit,
// one round per cycle, then the chaining add. No byte is accepted during a compression.
// End of message: padding bytes, one per cycle, up to offset 56, then the length words,
// one or two compressions, then five digest transactions; ready is low throughout.
// Reset: chaining value to the standard initial values, counts cleared, buffer left as is.
module sha0_message_digest import sha0_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_valid,
	input  logic        end_of_message,
	output logic        digest_valid,
	input  logic        digest_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	state_t      state_q, state_d;
	logic [5:0]  fill_q;
	logic [5:0]  fill_inc;
	logic [63:0] bitlen_q;
	logic [6:0]  round_q;
	logic [2:0]  word_q;
	logic        pad_q;
	logic        pad_first_q;
	logic        final_q;

	buf_ctl_t buf_ctl;
	rnd_ctl_t rnd_ctl;
	word_t    w;
	word_t    h [NUM_WORDS];

	logic in_fire;
	logic out_fire;

	assign fill_inc = fill_q + 6'd1;
	assign in_fire  = valid && ready;
	assign out_fire = digest_valid && digest_ready;

	sha0_buf u_buf (
		.clk (clk),
		.ctl (buf_ctl),
		.w   (w)
	);

	sha0_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (rnd_ctl),
		.w      (w),
		.h      (h)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		ready        = 1'b0;
		digest_valid = 1'b0;

		buf_ctl          = '0;
		buf_ctl.fill     = fill_q;
		buf_ctl.bit_len  = bitlen_q;
		rnd_ctl          = '0;
		rnd_ctl.round    = round_q;

		unique case (state_q)
			ST_IDLE: begin
				ready = 1'b1;
				buf_ctl.byte_val = data_byte;
				if (valid) begin
					buf_ctl.byte_en = byte_valid;
					if (byte_valid && fill_inc == 6'd0) begin
						rnd_ctl.start = 1'b1;
						state_d = ST_ROUND;
					end else if (end_of_message) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				buf_ctl.byte_en  = 1'b1;
				buf_ctl.byte_val = pad_first_q ? PAD_BYTE : 8'h00;
				if (fill_inc == 6'd0) begin
					rnd_ctl.start = 1'b1;
					state_d = ST_ROUND;
				end else if (fill_inc == LEN_FILL) begin
					state_d = ST_LEN;
				end
			end
			ST_LEN: begin
				buf_ctl.len_en = 1'b1;
				rnd_ctl.start  = 1'b1;
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				rnd_ctl.step  = 1'b1;
				buf_ctl.shift = 1'b1;
				if (round_q == LAST_ROUND) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				rnd_ctl.finish = 1'b1;
				if (final_q) begin
					state_d = ST_EMIT;
				end else if (pad_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				digest_valid = 1'b1;
				if (digest_ready && word_q == LAST_WORD) begin
					rnd_ctl.reinit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			bitlen_q    <= '0;
			round_q     <= '0;
			word_q      <= '0;
			pad_q       <= 1'b0;
			pad_first_q <= 1'b0;
			final_q     <= 1'b0;
		end else begin
			if (in_fire) begin
				if (byte_valid) begin
					fill_q   <= fill_inc;
					bitlen_q <= bitlen_q + BITS_PER_BYTE;
				end
				pad_q       <= end_of_message;
				pad_first_q <= end_of_message;
			end
			if (state_q == ST_PAD) begin
				fill_q      <= fill_inc;
				pad_first_q <= 1'b0;
			end
			if (state_q == ST_LEN) begin
				final_q <= 1'b1;
			end
			if (state_q == ST_ROUND) begin
				round_q <= (round_q == LAST_ROUND) ? 7'd0 : round_q + 7'd1;
			end
			if (out_fire) begin
				if (word_q == LAST_WORD) begin
					// start the next message from a clean state
					word_q   <= '0;
					fill_q   <= '0;
					bitlen_q <= '0;
					pad_q    <= 1'b0;
					final_q  <= 1'b0;
				end else begin
					word_q <= word_q + 3'd1;
				end
			end
		end
	end

	always_comb begin
		case (word_q)
			3'd0:    digest_word = h[0];
			3'd1:    digest_word = h[1];
			3'd2:    digest_word = h[2];
			3'd3:    digest_word = h[3];
			default: digest_word = h[4];
		endcase
	end

	assign word_index = word_q;
	assign last_word  = (word_q == LAST_WORD);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ready && digest_valid))
		else $error("input taken while digest is being delivered");

	a_back_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(digest_valid && digest_ready && last_word) |=> (ready && fill_q == 6'd0))
		else $error("core not cleared after final digest word");

	a_word_range: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid |-> (word_index <= LAST_WORD))
		else $error("digest word index out of range");

	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (round_q <= LAST_ROUND))
		else $error("round counter out of range");

endmodule

>>> rtl/core/sha0_buf.sv
// Block buffer: big-endian byte packing, length words and the rolling message schedule.
module sha0_buf import sha0_pkg::*; (
	input  logic     clk,
	input  buf_ctl_t ctl,
	output word_t    w
);

	word_t buf_q [BUF_WORDS];

	logic [3:0] idx;
	logic [1:0] lane;
	word_t      byte_word;
	word_t      next_w;

	assign idx  = ctl.fill[5:2];
	assign lane = ctl.fill[1:0];
	assign byte_word = {24'b0, ctl.byte_val} << {2'd3 - lane, 3'b000};

	// w[r+16] from the window holding w[r] .. w[r+15]
	assign next_w = buf_q[13] ^ buf_q[8] ^ buf_q[2] ^ buf_q[0];

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			for (int i = 0; i < BUF_WORDS - 1; i++) begin
				buf_q[i] <= buf_q[i + 1];
			end
			buf_q[BUF_WORDS - 1] <= next_w;
		end else if (ctl.len_en) begin
			buf_q[14] <= ctl.bit_len[63:32];
			buf_q[15] <= ctl.bit_len[31:0];
		end else if (ctl.byte_en) begin
			// lane zero starts a fresh word
			if (lane == 2'd0) begin
				buf_q[idx] <= byte_word;
			end else begin
				buf_q[idx] <= buf_q[idx] | byte_word;
			end
		end
	end

	assign w = buf_q[0];

endmodule

>>> rtl/core/sha0_round.sv
// Shared compression round unit and chaining value registers.
module sha0_round import sha0_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  rnd_ctl_t ctl,
	input  word_t    w,
	output word_t    h [NUM_WORDS]
);

	word_t a_q, b_q, c_q, d_q, e_q;
	word_t h_q [NUM_WORDS];
	word_t t;

	assign t = {a_q[26:0], a_q[31:27]} + round_f(ctl.round, b_q, c_q, d_q) + e_q + w
		+ round_k(ctl.round);

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (ctl.step) begin
			e_q <= d_q;
			d_q <= c_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			b_q <= a_q;
			a_q <= t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= INIT_HASH;
		end else if (ctl.reinit) begin
			h_q <= INIT_HASH;
		end else if (ctl.finish) begin
			h_q[0] <= h_q[0] + a_q;
			h_q[1] <= h_q[1] + b_q;
			h_q[2] <= h_q[2] + c_q;
			h_q[3] <= h_q[3] + d_q;
			h_q[4] <= h_q[4] + e_q;
		end
	end

	assign h = h_q;

endmodule
